// ===== design/mcr_pkg.sv =====
// mcr_pkg: shared types and constants of the multitap comb reverb
// holds the tap delay table, register codes, reset values and the control struct
// no dependencies
package mcr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TABLE_LEN = 18;
  localparam int TAB_W     = 5;
  localparam int DELAY_W   = 8;

  // register codes, one per register word; word 3 of the config space is unmapped
  typedef enum logic [1:0] {
    REG_INPUT_GAIN = 2'd0,
    REG_FB_START   = 2'd1,
    REG_FB_STEP    = 2'd2
  } mcr_reg_e;

  localparam logic signed [SAMPLE_W-1:0] INPUT_GAIN_RST = -16'sd8192;
  localparam logic signed [SAMPLE_W-1:0] FB_START_RST   = -16'sd6554;
  localparam logic signed [SAMPLE_W-1:0] FB_STEP_RST    = 16'sd328;

  // control strobes from the sequencer to each channel datapath
  typedef struct packed {
    logic accept;  // input item taken, capture sample
    logic go;      // center entry present, form x+b and dry term
    logic tap_a;   // tap read issued, form feedback product
    logic tap_b;   // tap entry present, form rounded tap term
  } mcr_ctrl_t;

  // prime tap delays
  function automatic logic [DELAY_W-1:0] tap_delay(input logic [TAB_W-1:0] idx);
    logic [DELAY_W-1:0] d;
    case (idx)
      5'd0:    d = 8'd101;
      5'd1:    d = 8'd103;
      5'd2:    d = 8'd107;
      5'd3:    d = 8'd109;
      5'd4:    d = 8'd113;
      5'd5:    d = 8'd127;
      5'd6:    d = 8'd131;
      5'd7:    d = 8'd137;
      5'd8:    d = 8'd139;
      5'd9:    d = 8'd149;
      5'd10:   d = 8'd151;
      5'd11:   d = 8'd157;
      5'd12:   d = 8'd163;
      5'd13:   d = 8'd167;
      5'd14:   d = 8'd173;
      5'd15:   d = 8'd179;
      5'd16:   d = 8'd181;
      5'd17:   d = 8'd191;
      default: d = 8'd101;
    endcase
    return d;
  endfunction

endpackage

// ===== design/mcr_ram.sv =====
// mcr_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
module mcr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mcr_chan_dp.sv =====
// mcr_chan_dp: arithmetic of one channel, output sum and tap accumulate
// depends on mcr_pkg for the control struct
module mcr_chan_dp
  import mcr_pkg::*;
#(
  parameter int ACC_WIDTH = 24
) (
  input  logic                        clk_i,
  input  mcr_ctrl_t                   ctrl_i,
  input  logic signed [SAMPLE_W-1:0]  x_i,
  input  logic signed [SAMPLE_W-1:0]  gain_i,
  input  logic signed [SAMPLE_W-1:0]  fb_i,
  input  logic signed [ACC_WIDTH-1:0] b_i,
  output logic signed [SAMPLE_W-1:0]  sample_o,
  output logic signed [ACC_WIDTH-1:0] acc_o
);

  localparam int PW = ACC_WIDTH + 17;  // feedback product
  localparam int SW = ACC_WIDTH + 18;  // dry + product + rounding
  localparam int RW = ACC_WIDTH + 3;   // after the shift by 15
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0]  SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0]  SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SW-1:0]        ROUND   = SW'(16384);

  logic signed [SAMPLE_W-1:0]  x_q;
  logic signed [ACC_WIDTH:0]   s_d, s_q;
  logic signed [31:0]          dry_q;
  logic signed [PW-1:0]        s_ext, fb_ext, prod_q;
  logic signed [SW-1:0]        sum_w;
  logic signed [RW-1:0]        rnd_w;
  logic signed [ACC_WIDTH-1:0] term_d, term_q, b_c_q;
  logic signed [ACC_WIDTH:0]   acc_w;

  // exact x + b
  assign s_d = {{(ACC_WIDTH+1-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q} + {b_i[ACC_WIDTH-1], b_i};

  always_comb begin
    if ((&s_d[ACC_WIDTH:SAMPLE_W-1]) || !(|s_d[ACC_WIDTH:SAMPLE_W-1])) begin
      sample_o = s_d[SAMPLE_W-1:0];
    end else begin
      sample_o = s_d[ACC_WIDTH] ? SMP_MIN : SMP_MAX;
    end
  end

  assign s_ext  = {{(PW-ACC_WIDTH-1){s_q[ACC_WIDTH]}}, s_q};
  assign fb_ext = {{(PW-SAMPLE_W){fb_i[SAMPLE_W-1]}}, fb_i};

  // round half up then floor shift by 15
  assign sum_w = {{(SW-32){dry_q[31]}}, dry_q} + {prod_q[PW-1], prod_q} + ROUND;
  assign rnd_w = sum_w[SW-1:15];

  always_comb begin
    if ((&rnd_w[RW-1:ACC_WIDTH-1]) || !(|rnd_w[RW-1:ACC_WIDTH-1])) begin
      term_d = rnd_w[ACC_WIDTH-1:0];
    end else begin
      term_d = rnd_w[RW-1] ? ACC_MIN : ACC_MAX;
    end
  end

  // saturating accumulate into the tap entry
  assign acc_w = {b_c_q[ACC_WIDTH-1], b_c_q} + {term_q[ACC_WIDTH-1], term_q};

  always_comb begin
    if (acc_w[ACC_WIDTH] == acc_w[ACC_WIDTH-1]) begin
      acc_o = acc_w[ACC_WIDTH-1:0];
    end else begin
      acc_o = acc_w[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      x_q <= x_i;
    end
    if (ctrl_i.go) begin
      s_q   <= s_d;
      dry_q <= x_q * gain_i;
    end
    if (ctrl_i.tap_a) begin
      prod_q <= s_ext * fb_ext;
    end
    if (ctrl_i.tap_b) begin
      term_q <= term_d;
      b_c_q  <= b_i;
    end
  end

endmodule

// ===== design/multitap_comb_reverb.sv =====
// multitap_comb_reverb: stereo multitap feedback comb reverb, top level
// flow: the result is registered into the output register when ST_CAPTURE sees it free, later
// while an earlier result still waits there; a new item is taken only after the tap sweep drains,
// paced by one ring read-modify-write per tap on the single ram port
// reset: async active low; clears control state, loads register defaults, then a clearing
// pass zeroes the ring, one entry a cycle over all RING_DEPTH entries, with tready held low
module multitap_comb_reverb
  import mcr_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int TAP_COUNT  = 18,
  parameter int ACC_WIDTH  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] left_in, [31:16] right_in
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] left_out, [31:16] right_out
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int KW  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int FBW = SAMPLE_W + $clog2(TAP_COUNT + 1) + 1;
  localparam int EW  = 2 * ACC_WIDTH;
  localparam logic [AW:0]   DEPTH_L   = (AW+1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_POS  = AW'(RING_DEPTH - 1);
  localparam logic [KW-1:0] LAST_TAP  = KW'(TAP_COUNT - 1);
  localparam logic [TAB_W-1:0] LAST_TAB = TAB_W'(TABLE_LEN - 1);
  localparam logic signed [SAMPLE_W-1:0] FB_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] FB_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR,    // zeroing the ring after reset
    ST_IDLE,     // waiting for an item, center read issued on accept
    ST_CAPTURE,  // center entry present, waits for a free output register
    ST_TAPS,     // one tap read issued per cycle
    ST_DRAIN     // last tap terms going through to the write port
  } state_e;

  // config registers
  logic signed [SAMPLE_W-1:0] input_gain_q, feedback_start_q, feedback_step_q;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_gain_q     <= INPUT_GAIN_RST;
      feedback_start_q <= FB_START_RST;
      feedback_step_q  <= FB_STEP_RST;
    end else if (cfg_we) begin
      case (mcr_reg_e'(paddr[3:2]))
        REG_INPUT_GAIN: input_gain_q     <= pwdata[SAMPLE_W-1:0];
        REG_FB_START:   feedback_start_q <= pwdata[SAMPLE_W-1:0];
        REG_FB_STEP:    feedback_step_q  <= pwdata[SAMPLE_W-1:0];
        default: ;  // writes outside the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (mcr_reg_e'(paddr[3:2]))
      REG_INPUT_GAIN: prdata = {16'd0, input_gain_q};
      REG_FB_START:   prdata = {16'd0, feedback_start_q};
      REG_FB_STEP:    prdata = {16'd0, feedback_step_q};
      default:        prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_e                   state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic [KW-1:0]            k_q, k_d;
  logic [TAB_W-1:0]         tab_q, tab_d;
  logic signed [FBW-1:0]    fb_raw_q, fb_raw_d;
  logic                     tap_b_q, tap_c_q;
  logic [AW-1:0]            addr_b_q, addr_c_q;
  logic                     m_tvalid_q, m_tvalid_d;
  logic [31:0]              m_tdata_q, m_tdata_d;

  logic                     accept, go, tap_a, clear_we;
  logic signed [SAMPLE_W-1:0] fb_sat;
  logic [AW:0]              tap_sum;
  logic [AW-1:0]            tap_addr;
  mcr_ctrl_t                ctrl;

  // ram ports
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [EW-1:0]            ram_wdata, ram_rdata;

  // channel datapaths
  logic signed [SAMPLE_W-1:0]  smp_l, smp_r;
  logic signed [ACC_WIDTH-1:0] acc_l, acc_r;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  // the output register frees up when its item leaves in the same cycle
  assign go            = (state_q == ST_CAPTURE) & (~m_tvalid_q | m_axis_tready);
  assign tap_a         = (state_q == ST_TAPS);
  assign clear_we      = (state_q == ST_CLEAR);

  assign ctrl = '{accept: accept, go: go, tap_a: tap_a, tap_b: tap_b_q};

  // feedback gain of the current tap, clamped to q1.15
  always_comb begin
    if ((&fb_raw_q[FBW-1:SAMPLE_W-1]) || !(|fb_raw_q[FBW-1:SAMPLE_W-1])) begin
      fb_sat = fb_raw_q[SAMPLE_W-1:0];
    end else begin
      fb_sat = fb_raw_q[FBW-1] ? FB_MIN : FB_MAX;
    end
  end

  // tap position, wraps with one compare since every delay is below the ring depth
  assign tap_sum = {1'b0, pos_q} + (AW+1)'(tap_delay(tab_q));
  always_comb begin
    if (tap_sum >= DEPTH_L) begin
      tap_addr = AW'(tap_sum - DEPTH_L);
    end else begin
      tap_addr = tap_sum[AW-1:0];
    end
  end

  // one read port: center entry on accept, tap entries during the tap sweep
  assign ram_re    = accept | tap_a;
  assign ram_raddr = tap_a ? tap_addr : pos_q;

  // one write port: clearing pass, clearing of the center entry, tap write-back.
  // taps never land on the center entry and no two taps of one sweep share an entry,
  // so a tap read never meets an outstanding write to the same entry
  assign ram_we = clear_we | go | tap_c_q;
  always_comb begin
    if (clear_we) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (go) begin
      ram_waddr = pos_q;
      ram_wdata = '0;
    end else begin
      ram_waddr = addr_c_q;
      ram_wdata = {acc_r, acc_l};
    end
  end

  mcr_ram #(
    .WIDTH (EW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mcr_chan_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_left (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .x_i      (s_axis_tdata[15:0]),
    .gain_i   (input_gain_q),
    .fb_i     (fb_sat),
    .b_i      (ram_rdata[ACC_WIDTH-1:0]),
    .sample_o (smp_l),
    .acc_o    (acc_l)
  );

  mcr_chan_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_right (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .x_i      (s_axis_tdata[31:16]),
    .gain_i   (input_gain_q),
    .fb_i     (fb_sat),
    .b_i      (ram_rdata[EW-1:ACC_WIDTH]),
    .sample_o (smp_r),
    .acc_o    (acc_r)
  );

  // next state and registered outputs
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pos_d      = pos_q;
    k_d        = k_q;
    tab_d      = tab_q;
    fb_raw_d   = fb_raw_q;
    m_tvalid_d = m_tvalid_q & ~m_axis_tready;
    m_tdata_d  = m_tdata_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_POS) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CAPTURE;
        end
      end
      ST_CAPTURE: begin
        if (go) begin
          state_d    = ST_TAPS;
          m_tvalid_d = 1'b1;
          m_tdata_d  = {smp_r, smp_l};
          k_d        = '0;
          tab_d      = '0;
          fb_raw_d   = FBW'(feedback_start_q);
        end
      end
      ST_TAPS: begin
        k_d      = k_q + 1'b1;
        tab_d    = (tab_q == LAST_TAB) ? '0 : tab_q + 1'b1;
        fb_raw_d = fb_raw_q + FBW'(feedback_step_q);
        if (k_q == LAST_TAP) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last tap write-back happens this cycle
        if (tap_c_q && !tap_b_q) begin
          state_d = ST_IDLE;
          pos_d   = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      pos_q      <= '0;
      k_q        <= '0;
      tab_q      <= '0;
      fb_raw_q   <= '0;
      tap_b_q    <= 1'b0;
      tap_c_q    <= 1'b0;
      addr_b_q   <= '0;
      addr_c_q   <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pos_q      <= pos_d;
      k_q        <= k_d;
      tab_q      <= tab_d;
      fb_raw_q   <= fb_raw_d;
      tap_b_q    <= tap_a;
      tap_c_q    <= tap_b_q;
      addr_b_q   <= tap_addr;
      addr_c_q   <= addr_b_q;
      m_tvalid_q <= m_tvalid_d;
      m_tdata_q  <= m_tdata_d;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // a tap write-back never hits the entry being read out and cleared
  a_tap_not_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_c_q |-> (addr_c_q != pos_q))
    else $error("tap write-back hit the center entry");

  // at most one source drives the ram write port
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({clear_we, go, tap_c_q}))
    else $error("ram write port conflict");

  // a new item only starts once the previous tap sweep has drained
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!tap_b_q && !tap_c_q && !tap_a))
    else $error("item accepted while tap writes pending");

  // a finished result is never overwritten before it is taken
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && !m_axis_tready) |=> (m_tvalid_q && $stable(m_tdata_q)))
    else $error("pending result lost");

endmodule

// ===== dv/multitap_comb_reverb_test.sv =====
`timescale 1ns / 100ps
// multitap_comb_reverb_test: self-checking testbench of the stereo multitap comb reverb
// predicts every wet sample from its own fixed-point ring model; needs mcr_pkg and the top level
module multitap_comb_reverb_test
  import mcr_pkg::*;
();

  localparam int RING_N = 256;
  localparam int TAPS = 18;
  localparam int ACC_W = 24;
  // cycles the block may still spend on tap updates after a result has left
  localparam int TAIL_CYCLES = TAPS + 8;
  // word index past the last register, writes there must be dropped
  localparam int REG_UNMAPPED = 3;
  localparam longint ACC_MAX = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  // prime tap delays, tap 0 in the lowest byte
  localparam logic [TAPS*8-1:0] TAP_DELAYS = {
    8'd191, 8'd181, 8'd179, 8'd173, 8'd167, 8'd163, 8'd157, 8'd151, 8'd149,
    8'd139, 8'd137, 8'd131, 8'd127, 8'd113, 8'd109, 8'd107, 8'd103, 8'd101
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } stereo_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] left_in, [31:16] right_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] left_out, [31:16] right_out
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block: ring accumulators, read position and gains
  logic signed [ACC_W-1:0]    ring_acc [RING_N][2];
  int                         ring_pos;
  logic signed [SAMPLE_W-1:0] dry_gain;
  logic signed [SAMPLE_W-1:0] fb_base;
  logic signed [SAMPLE_W-1:0] fb_incr;

  stereo_t wet_expected[$];
  stereo_t wet_want;
  stereo_t wet_got;

  bit steady_flow;
  int fail_count;
  int samples_sent;
  int wet_checked;
  int reg_writes;

  multitap_comb_reverb dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int tap_delay_of(input int k);
    return int'(TAP_DELAYS[k*8 +: 8]);
  endfunction

  function automatic logic [3:0] reg_addr(input int idx);
    return 4'(idx * 4);
  endfunction

  // mostly full-range values, with the rails and quiet signals mixed in
  function automatic logic signed [SAMPLE_W-1:0] rand_q15();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      2: v = 16'($urandom_range(0, 255)) - 16'd128;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  // one stereo sample through the ring: read the center entry, spread the
  // tap terms ahead of it, then clear it and step the position
  task automatic predict_echo(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right);
    longint  x;
    longint  s;
    longint  dry;
    longint  fb;
    longint  term;
    int      idx;
    stereo_t wet;
    for (int ch = 0; ch < 2; ch++) begin
      x   = (ch == 0) ? longint'(left) : longint'(right);
      s   = x + longint'(ring_acc[ring_pos][ch]);
      dry = x * longint'(dry_gain);
      for (int k = 0; k < TAPS; k++) begin
        // feedback gain ramps per tap and pins at the Q1.15 rails
        fb   = clamp(longint'(fb_base) + k * longint'(fb_incr), -32768, 32767);
        // Q.30 sum, round half up to Q.15, then fit the accumulator
        term = clamp((dry + s * fb + 16384) >>> 15, ACC_MIN, ACC_MAX);
        idx  = (ring_pos + tap_delay_of(k)) % RING_N;
        ring_acc[idx][ch] =
          ACC_W'(clamp(longint'(ring_acc[idx][ch]) + term, ACC_MIN, ACC_MAX));
      end
      if (ch == 0) begin
        wet.left = SAMPLE_W'(clamp(s, -32768, 32767));
      end else begin
        wet.right = SAMPLE_W'(clamp(s, -32768, 32767));
      end
    end
    ring_acc[ring_pos][0] = '0;
    ring_acc[ring_pos][1] = '0;
    ring_pos = (ring_pos + 1) % RING_N;
    wet_expected.push_back(wet);
  endtask

  // watch all three ports at each edge; values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INPUT_GAIN: dry_gain = pwdata[15:0];
          REG_FB_START:   fb_base  = pwdata[15:0];
          REG_FB_STEP:    fb_incr  = pwdata[15:0];
          default: ;  // unmapped word, nothing changes
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_echo(s_axis_tdata[15:0], s_axis_tdata[31:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        wet_got = m_axis_tdata;
        wet_checked++;
        if (wet_expected.size() == 0) begin
          $error("unexpected result item: left_out %0d right_out %0d",
                 wet_got.left, wet_got.right);
          fail_count++;
        end else begin
          wet_want = wet_expected.pop_front();
          if (wet_got.left !== wet_want.left) begin
            $error("left_out mismatch: expected %0d, got %0d", wet_want.left, wet_got.left);
            fail_count++;
          end
          if (wet_got.right !== wet_want.right) begin
            $error("right_out mismatch: expected %0d, got %0d", wet_want.right,
                   wet_got.right);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: random stall before each item unless running flat out
  initial begin : sink
    int sink_hold;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      sink_hold = steady_flow ? 0 : $urandom_range(0, 5);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // offer one stereo sample after a random gap unless running flat out; valid stays up on return
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] left,
                             input logic signed [SAMPLE_W-1:0] right);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
  endtask

  // stop sending, let every result drain and the tap updates finish
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (wet_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  // upper data bits are junk on purpose, only the low half counts
  task automatic set_reverb(input logic signed [SAMPLE_W-1:0] gain,
                            input logic signed [SAMPLE_W-1:0] start,
                            input logic signed [SAMPLE_W-1:0] step);
    settle_block();
    apb_write(reg_addr(REG_INPUT_GAIN), {16'($urandom()), gain});
    apb_write(reg_addr(REG_FB_START), {16'($urandom()), start});
    apb_write(reg_addr(REG_FB_STEP), {16'($urandom()), step});
  endtask

  task automatic play_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_sample(rand_q15(), rand_q15());
    end
  endtask

  // rails and sign corners of both channels at the reset gains
  task automatic test_sample_extremes();
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'shffff, 16'sh0001);
    send_sample(16'sh0001, 16'shffff);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh5555, 16'shaaaa);
    send_sample(16'shaaaa, 16'sh5555);
    send_sample(16'sh4000, 16'shc000);
    send_sample(16'sh8001, 16'sh7ffe);
    send_sample(16'sh0000, 16'sh7fff);
  endtask

  // long stream at reset gains so the ring position wraps around the ring once,
  // with a full drain halfway through
  task automatic test_default_stream();
    play_random(150);
    settle_block();
    play_random(150);
  endtask

  // a write past the register list must leave all gains alone
  task automatic test_unmapped_register();
    settle_block();
    apb_write(reg_addr(REG_UNMAPPED), $urandom());
    play_random(50);
  endtask

  // top rails: the feedback ramp overflows high and the ring saturates
  task automatic test_max_gains();
    set_reverb(16'sh7fff, 16'sh7fff, 16'sh7fff);
    play_random(150);
  endtask

  // bottom rails: the ramp overflows low
  task automatic test_min_gains();
    set_reverb(16'sh8000, 16'sh8000, 16'sh8000);
    play_random(150);
  endtask

  // a ramp that crosses zero with no dry path, then random settings
  task automatic test_random_settings();
    set_reverb(16'sh0000, 16'sh7fff, 16'sh8000);
    play_random(100);
    for (int i = 0; i < 3; i++) begin
      set_reverb(rand_q15(), rand_q15(), rand_q15());
      play_random(100);
    end
  endtask

  // no gaps and no stalls at all
  task automatic test_back_to_back();
    set_reverb(INPUT_GAIN_RST, FB_START_RST, FB_STEP_RST);
    steady_flow = 1'b1;
    play_random(150);
    settle_block();
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    steady_flow  = 1'b0;
    fail_count   = 0;
    samples_sent = 0;
    wet_checked  = 0;
    reg_writes   = 0;
    ring_pos     = 0;
    dry_gain     = INPUT_GAIN_RST;
    fb_base      = FB_START_RST;
    fb_incr      = FB_STEP_RST;
    for (int i = 0; i < RING_N; i++) begin
      ring_acc[i][0] = '0;
      ring_acc[i][1] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sample_extremes();
    test_default_stream();
    test_unmapped_register();
    test_max_gains();
    test_min_gains();
    test_random_settings();
    test_back_to_back();

    settle_block();
    $display("stimulus: %0d stereo samples, %0d register writes; %0d results checked",
             samples_sent, reg_writes, wet_checked);
    $display("settings: reset, rail and random gains, saturating feedback, gapless bursts");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== multitap_comb_reverb.f =====
design/mcr_pkg.sv
design/mcr_ram.sv
design/mcr_chan_dp.sv
design/multitap_comb_reverb.sv
dv/multitap_comb_reverb_test.sv
